// File: rtl/pfr_pkg.sv
// Package for the pulse flow rate estimator: field widths, register indexes,
// reset values and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

  localparam int TIME_W     = 32;
  localparam int RATE_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int NUMER_W    = 24;
  localparam int HOLDOFF_W  = 32;
  localparam int MINCHG_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_RATE_NUMERATOR = 2'd0;
  localparam cfg_idx_t REG_CHANGE_HOLDOFF = 2'd1;
  localparam cfg_idx_t REG_MIN_CHANGE     = 2'd2;

  // Register reset values
  localparam logic [NUMER_W-1:0]   NUMER_RESET   = 24'd1000000;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 32'd30000;
  localparam logic [MINCHG_W-1:0]  MINCHG_RESET  = 16'd5;

  // Poll sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PULSE,
    S_DIV,
    S_STEP,
    S_GATE,
    S_HOLD,
    S_DECAY,
    S_DIFF,
    S_REPORT,
    S_OUT
  } pfr_state_t;

endpackage

`default_nettype wire

// File: rtl/pfr_in_if.sv
// Input channel of the pulse flow rate estimator: one poll word per handshake.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface pfr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        pin_level;

  modport source (output valid, output now_ms, output pin_level, input ready);
  modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

`default_nettype wire

// File: rtl/pfr_out_if.sv
// Result channel of the pulse flow rate estimator: one result word per poll.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface pfr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pulse_count;
  logic [31:0] current_rate;
  logic [31:0] reported_rate;
  logic        change_event;

  modport source (output valid, output pulse_count, output current_rate,
                  output reported_rate, output change_event, input ready);
  modport sink   (input valid, input pulse_count, input current_rate,
                  input reported_rate, input change_event, output ready);
endinterface

`default_nettype wire

// File: rtl/pfr_serial_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by pulse_flow_rate_estimator.
`timescale 1ns / 1ps
`default_nettype none

module pfr_serial_div #(
  parameter int DW = 32,
  parameter int VW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quotient,
  output logic               done
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;

  logic [VW:0]   trial;
  logic [VW+1:0] diff;
  logic          fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign fits  = ~diff[VW+1];

  // Load on start, then shift one quotient bit in per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CW'(DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[DW-2:0], fits};
      rem_nxt = fits ? diff[VW-1:0] : trial[VW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// File: rtl/pulse_flow_rate_estimator.sv
// Pulse flow rate estimator top level: poll sequencer, state and config.
// Depends on pfr_pkg, pfr_in_if, pfr_out_if and pfr_serial_div.
//
// Usage: each word on in_ch is one poll (millisecond timestamp, pin level).
// Every accepted poll yields exactly one word on out_ch: pulse count, current
// rate (unsigned Q(32-F).F, F = RATE_FRAC_BITS), last reported rate and a
// change flag. Registers are written on the cfg port (cfg_we, cfg_idx,
// cfg_wdata); the user must write them only while no poll is in flight, as
// the block itself does not enforce it; writes to unknown indexes drop.
// A poll without a new pulse passes S_PULSE, S_GATE, S_HOLD, S_DECAY,
// S_DIFF, S_REPORT and S_OUT before its word reaches the result register.
// A poll with a new pulse and a nonzero interval adds the bit-serial rate
// division (S_DIV) and the division of the rate by DECAY_STEPS (S_STEP).
// The decay period division runs alongside the rate division.
// One poll is processed at a time; in_ch.ready is high only while idle.
// The result register holds a word until out_ch takes it; the next poll may
// be accepted and processed meanwhile, and it waits at the end if the
// receiver still stalls.
// Reset (rst_n low, synchronous) clears sequencer and estimator state, loads
// register defaults and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module pulse_flow_rate_estimator #(
  parameter int RATE_FRAC_BITS = 12,
  parameter int DECAY_STEPS    = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pfr_in_if.sink                               in_ch,
  pfr_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire pfr_pkg::cfg_idx_t               cfg_idx,
  input  wire logic [pfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import pfr_pkg::*;

  localparam int DIVN_W = NUMER_W + RATE_FRAC_BITS;
  localparam int QX_W   = (DIVN_W > RATE_W) ? DIVN_W : RATE_W;
  localparam int DS_W   = $clog2(DECAY_STEPS + 1);

  // Configuration registers
  logic [NUMER_W-1:0]   numer_r;
  logic [HOLDOFF_W-1:0] holdoff_r;
  logic [MINCHG_W-1:0]  minchg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numer_r   <= NUMER_RESET;
      holdoff_r <= HOLDOFF_RESET;
      minchg_r  <= MINCHG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RATE_NUMERATOR: numer_r   <= cfg_wdata[NUMER_W-1:0];
        REG_CHANGE_HOLDOFF: holdoff_r <= cfg_wdata[HOLDOFF_W-1:0];
        REG_MIN_CHANGE:     minchg_r  <= cfg_wdata[MINCHG_W-1:0];
        default:            ;
      endcase
    end
  end

  // Sequencer and estimator state
  pfr_state_t state_r, state_nxt;

  logic               seen_r, seen_nxt;
  logic [TIME_W-1:0]  last_pulse_r, last_pulse_nxt;
  logic [TIME_W-1:0]  last_decay_r, last_decay_nxt;
  logic [TIME_W-1:0]  last_change_r, last_change_nxt;
  logic [TIME_W-1:0]  interval_r, interval_nxt;
  logic [TIME_W-1:0]  period_r, period_nxt;
  logic [RATE_W-1:0]  step_r, step_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic [RATE_W-1:0]  rep_r, rep_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               event_r, event_nxt;

  // Per-poll working registers
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic               pin_r, pin_nxt;
  logic               gate_r, gate_nxt;
  logic               hold_r, hold_nxt;
  logic [RATE_W-1:0]  diff_r, diff_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [RATE_W-1:0]  out_rate_r, out_rate_nxt;
  logic [RATE_W-1:0]  out_rep_r, out_rep_nxt;
  logic               out_event_r, out_event_nxt;

  logic in_fire;
  logic out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Dividers
  logic              main_start, per_start, step_start;
  logic              main_done, per_done, step_done;
  logic [DIVN_W-1:0] main_dvd, main_quo;
  logic [TIME_W-1:0] per_quo;
  logic [RATE_W-1:0] step_quo;
  logic [TIME_W-1:0] ivl;
  logic [QX_W-1:0]   q_ext;
  logic [RATE_W-1:0] q_sat;

  assign ivl      = now_r - last_pulse_r;
  assign main_dvd = DIVN_W'(numer_r) << RATE_FRAC_BITS;
  assign q_ext    = QX_W'(main_quo);
  assign q_sat    = ((q_ext >> RATE_W) != '0) ? '1 : q_ext[RATE_W-1:0];

  pfr_serial_div #(.DW(DIVN_W), .VW(TIME_W)) u_div_rate (
    .clk(clk), .rst_n(rst_n), .start(main_start),
    .dividend(main_dvd), .divisor(ivl),
    .quotient(main_quo), .done(main_done)
  );

  pfr_serial_div #(.DW(TIME_W), .VW(DS_W)) u_div_period (
    .clk(clk), .rst_n(rst_n), .start(per_start),
    .dividend(ivl), .divisor(DS_W'(DECAY_STEPS)),
    .quotient(per_quo), .done(per_done)
  );

  pfr_serial_div #(.DW(RATE_W), .VW(DS_W)) u_div_step (
    .clk(clk), .rst_n(rst_n), .start(step_start),
    .dividend(q_sat), .divisor(DS_W'(DECAY_STEPS)),
    .quotient(step_quo), .done(step_done)
  );

  // Shared compares
  logic              new_pulse;
  logic [RATE_W:0]   dec_sub;
  logic              rate_le_step;
  logic [RATE_W-1:0] limit;
  logic              rate_ge_rep;

  assign new_pulse    = pin_r && !seen_r;
  assign dec_sub      = {1'b0, rate_r} - {1'b0, step_r};
  assign rate_le_step = dec_sub[RATE_W] || (dec_sub[RATE_W-1:0] == '0);
  assign limit        = RATE_W'(minchg_r) << RATE_FRAC_BITS;
  assign rate_ge_rep  = (rate_r >= rep_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_PULSE;
      S_PULSE:  state_nxt = (new_pulse && (ivl != '0)) ? S_DIV : S_GATE;
      S_DIV:    if (main_done) state_nxt = S_STEP;
      S_STEP:   if (step_done) state_nxt = S_GATE;
      S_GATE:   state_nxt = S_HOLD;
      S_HOLD:   state_nxt = S_DECAY;
      S_DECAY:  state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_REPORT;
      S_REPORT: state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    seen_nxt        = seen_r;
    last_pulse_nxt  = last_pulse_r;
    last_decay_nxt  = last_decay_r;
    last_change_nxt = last_change_r;
    interval_nxt    = interval_r;
    period_nxt      = period_r;
    step_nxt        = step_r;
    rate_nxt        = rate_r;
    rep_nxt         = rep_r;
    total_nxt       = total_r;
    event_nxt       = event_r;
    now_nxt         = now_r;
    pin_nxt         = pin_r;
    gate_nxt        = gate_r;
    hold_nxt        = hold_r;
    diff_nxt        = diff_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_count_nxt   = out_count_r;
    out_rate_nxt    = out_rate_r;
    out_rep_nxt     = out_rep_r;
    out_event_nxt   = out_event_r;
    main_start      = 1'b0;
    per_start       = 1'b0;
    step_start      = 1'b0;

    // Capture the decay period whenever its division finishes
    if (per_done) period_nxt = per_quo;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          now_nxt   = in_ch.now_ms;
          pin_nxt   = in_ch.pin_level;
          event_nxt = 1'b0;
        end
      end
      S_PULSE: begin
        if (!pin_r) begin
          seen_nxt = 1'b0;
        end else if (!seen_r) begin
          seen_nxt       = 1'b1;
          total_nxt      = total_r + 1'b1;
          interval_nxt   = ivl;
          last_pulse_nxt = now_r;
          if (ivl != '0) begin
            main_start = 1'b1;
            per_start  = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (main_done) begin
          rate_nxt   = q_sat;
          step_start = 1'b1;
        end
      end
      S_STEP: begin
        if (step_done) step_nxt = step_quo;
      end
      S_GATE: begin
        gate_nxt = ((now_r - last_pulse_r) > interval_r) && (period_r > TIME_W'(1));
      end
      S_HOLD: begin
        hold_nxt = (now_r - last_change_r) > holdoff_r;
      end
      S_DECAY: begin
        // If due, drop one step, or clear to zero and report a change to zero if the holdoff has passed
        if (gate_r && ((now_r - last_decay_r) > period_r)) begin
          last_decay_nxt = now_r;
          if (rate_le_step) begin
            rate_nxt = '0;
            if ((rep_r != '0) && hold_r) begin
              rep_nxt         = '0;
              last_change_nxt = now_r;
              event_nxt       = 1'b1;
            end
          end else begin
            rate_nxt = dec_sub[RATE_W-1:0];
          end
        end
      end
      S_DIFF: begin
        diff_nxt = rate_ge_rep ? (rate_r - rep_r) : (rep_r - rate_r);
      end
      S_REPORT: begin
        if (((diff_r > limit) || ((rep_r == '0) && (rate_r != '0))) && hold_r) begin
          rep_nxt         = rate_r;
          last_change_nxt = now_r;
          event_nxt       = 1'b1;
        end
      end
      S_OUT: begin
        // Hold until the result register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = total_r;
          out_rate_nxt  = rate_r;
          out_rep_nxt   = rep_r;
          out_event_nxt = event_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      seen_r        <= 1'b0;
      last_pulse_r  <= '0;
      last_decay_r  <= '0;
      last_change_r <= '0;
      interval_r    <= '0;
      period_r      <= '0;
      step_r        <= '0;
      rate_r        <= '0;
      rep_r         <= '0;
      total_r       <= '0;
      event_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      seen_r        <= seen_nxt;
      last_pulse_r  <= last_pulse_nxt;
      last_decay_r  <= last_decay_nxt;
      last_change_r <= last_change_nxt;
      interval_r    <= interval_nxt;
      period_r      <= period_nxt;
      step_r        <= step_nxt;
      rate_r        <= rate_nxt;
      rep_r         <= rep_nxt;
      total_r       <= total_nxt;
      event_r       <= event_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    now_r       <= now_nxt;
    pin_r       <= pin_nxt;
    gate_r      <= gate_nxt;
    hold_r      <= hold_nxt;
    diff_r      <= diff_nxt;
    out_count_r <= out_count_nxt;
    out_rate_r  <= out_rate_nxt;
    out_rep_r   <= out_rep_nxt;
    out_event_r <= out_event_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pulse_count   = out_count_r;
  assign out_ch.current_rate  = out_rate_r;
  assign out_ch.reported_rate = out_rep_r;
  assign out_ch.change_event  = out_event_r;

endmodule

`default_nettype wire
